@@ hw/rtl/ggl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ggl_pkg;

	// fixed field widths
	localparam int COORD_W    = 16;
	localparam int GNUM_W     = 5;
	localparam int OUTCOME_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 56;

	// internal arithmetic widths
	localparam int SPAN_W     = 19;   // box sizes, slot offsets, slot centers, reach
	localparam int DIFF_W     = 20;   // center minus gate coordinate
	localparam int DIST_W     = 40;   // squared distances
	localparam int GATE_TAG_W = 6;    // gate index carried down the distance pipe

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Z = 3'd1,
		REG_BOX_MAX_X = 3'd2,
		REG_BOX_MAX_Z = 3'd3,
		REG_BASE_Y    = 3'd4
	} cfg_reg_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUTCOME_OK        = 2'd0,
		OUTCOME_FEW_SLOTS = 2'd1,
		OUTCOME_UNREACHED = 2'd2
	} outcome_t;

	localparam logic KIND_PLACE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_CHECK,
		ST_SCAN,
		ST_WAIT,
		ST_PLACE,
		ST_STATUS
	} ggl_state_t;

	// tag that follows one gate read through the distance pipe
	typedef struct packed {
		logic                  vld;   // gate is unplaced, its distance counts
		logic                  last;  // last gate of this slot's scan
		logic [GATE_TAG_W-1:0] gate;
	} scan_tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/ggl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ggl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/ggl_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none

// two-stage squared distance: difference, then squares; the sum is combinational at the output
module ggl_dist
	import ggl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  scan_tag_t                tag_in,
	input  logic signed [COORD_W-1:0] gate_x,
	input  logic signed [COORD_W-1:0] gate_z,
	input  logic signed [SPAN_W-1:0]  center_x,
	input  logic signed [SPAN_W-1:0]  center_z,
	output scan_tag_t                tag_out,
	output logic [DIST_W-1:0]         dist2
);

	scan_tag_t                 tag_s2, tag_s3;
	logic signed [DIFF_W-1:0]  dx_s2, dz_s2;
	logic signed [DIST_W-1:0]  sqx_s3, sqz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= DIFF_W'(center_x) - DIFF_W'(gate_x);
		dz_s2  <= DIFF_W'(center_z) - DIFF_W'(gate_z);
		sqx_s3 <= dx_s2 * dx_s2;
		sqz_s3 <= dz_s2 * dz_s2;
	end

	assign tag_out = tag_s3;
	assign dist2   = sqx_s3 + sqz_s3;

endmodule

`default_nettype wire

@@ hw/rtl/greedy_grid_legalizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | beat contents (lsb first)                                  | accepted when
// --------+-----+-------------------------------------------------------------+-------------------
// s_*     | in  | tdata: gate_pos_x, gate_pos_z; tlast: final_gate            | s_tvalid & s_tready
// m_*     | out | tdata: gate_number, legal_x/y/z, outcome; tuser: result_kind;| m_tvalid & m_tready
//         |     | tlast: run_end                                              |
// cfg_*   | in  | cfg_index: register number, cfg_data: 16-bit value          | cfg_valid & cfg_ready
//
// a non-final gate beat is stored and the block stays ready for the next beat
// a final beat starts a run: a size state counts slots per axis, a check state compares slots
// with gates, then per slot every loaded gate is read through the single gate-store read port
// feeding one distance unit; each emitted record waits while the output is stalled
// reset clears the config registers, counters and placed marks; the gate store needs no clear
// no gate beats are taken during a run; config writes are taken at any time

module greedy_grid_legalizer_core
	import ggl_pkg::*;
#(
	parameter int MAX_GATES  = 32,
	parameter int SLOT_PITCH = 3
)(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // [15:0] gate_pos_x, [31:16] gate_pos_z
	input  logic                 s_tlast,   // final_gate

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // [4:0] gate_number, [20:5] legal_x,
	                                        // [36:21] legal_y, [52:37] legal_z,
	                                        // [54:53] outcome, [55] zero
	output logic [0:0]           m_tuser,   // [0] result_kind
	output logic                 m_tlast,   // run_end

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	localparam int AW    = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int CW    = $clog2(MAX_GATES + 1);
	localparam int RAM_W = 2 * COORD_W;

	localparam logic signed [SPAN_W-1:0] PITCH_S = SPAN_W'(SLOT_PITCH);
	localparam logic signed [SPAN_W-1:0] HALF_S  = SPAN_W'(SLOT_PITCH / 2);
	localparam logic signed [SPAN_W-1:0] ONE_S   = SPAN_W'(1);
	localparam logic [CW-1:0]            FULL    = CW'(MAX_GATES);
	localparam logic [CW-1:0]            SZ_LAST = CW'(MAX_GATES - 1);

	// fsm
	ggl_state_t state_q, state_d;

	// config registers
	logic signed [COORD_W-1:0] min_x_q, min_z_q, max_x_q, max_z_q, base_y_q;

	// run control
	logic [CW-1:0]        loaded_q, unplaced_q;
	logic [MAX_GATES-1:0] placed_q;
	logic [CW-1:0]        sz_cnt_q, xb_q, zb_q;
	logic [AW-1:0]        g_q;
	logic                 found_q;
	outcome_t             outcome_q;
	scan_tag_t            tag_s1;

	// run payload
	logic signed [SPAN_W-1:0] xsize_q, zsize_q, sz_acc_q;
	logic signed [SPAN_W-1:0] col_off_q, row_off_q;
	logic [DIST_W-1:0]        reach2_q, best_q;
	logic [AW-1:0]            pick_q;

	// output register
	logic                 m_tvalid_q, m_kind_q, m_last_q;
	logic [GNUM_W-1:0]    m_gnum_q;
	logic [COORD_W-1:0]   m_x_q, m_y_q, m_z_q;
	logic [OUTCOME_W-1:0] m_outcome_q;

	// strobes
	logic s_accept, cfg_accept, store_we, out_free;
	logic issue, emit_place, emit_stat, no_reach;

	// datapath nets
	logic [RAM_W-1:0]          rdata;
	scan_tag_t                 tag_issue, dist_tag;
	logic [DIST_W-1:0]         dist2;
	logic                      better, scan_last, few_slots;
	logic signed [SPAN_W-1:0]  center_x, center_z, acc_next, reach;
	logic signed [SPAN_W-1:0]  row_next, col_next;
	logic                      row_fits, col_fits;
	logic signed [DIST_W-1:0]  reach_sq;
	logic [2*CW-1:0]           slot_cnt;

	assign s_accept   = s_tvalid & s_tready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid & cfg_ready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign store_we   = s_accept && (loaded_q != FULL);

	// slot geometry
	assign center_x  = SPAN_W'(min_x_q) + col_off_q + HALF_S;
	assign center_z  = SPAN_W'(min_z_q) + row_off_q + HALF_S;
	assign row_next  = row_off_q + PITCH_S;
	assign col_next  = col_off_q + PITCH_S;
	assign row_fits  = (row_next + PITCH_S) <= zsize_q;
	assign col_fits  = (col_next + PITCH_S) <= xsize_q;
	assign acc_next  = sz_acc_q + PITCH_S;
	assign reach     = xsize_q + zsize_q;
	assign reach_sq  = reach * reach;
	assign slot_cnt  = xb_q * zb_q;
	assign few_slots = slot_cnt < (2 * CW)'(loaded_q);

	assign scan_last = (CW'(g_q) + CW'(1)) == loaded_q;
	assign better    = dist_tag.vld && (dist2 < best_q);

	always_comb begin
		tag_issue      = '0;
		tag_issue.vld  = issue && !placed_q[g_q];
		tag_issue.last = issue && scan_last;
		tag_issue.gate = GATE_TAG_W'(g_q);
	end

	// gate store: x in the low half, z in the high half
	ggl_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_GATES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (loaded_q[AW-1:0]),
		.wdata (s_tdata[RAM_W-1:0]),
		.raddr (g_q),
		.rdata (rdata)
	);

	ggl_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_in   (tag_s1),
		.gate_x   (rdata[COORD_W-1:0]),
		.gate_z   (rdata[RAM_W-1:COORD_W]),
		.center_x (center_x),
		.center_z (center_z),
		.tag_out  (dist_tag),
		.dist2    (dist2)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && s_tlast) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				if (sz_cnt_q == SZ_LAST) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = few_slots ? ST_STATUS : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (dist_tag.last) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				if (!found_q) begin
					state_d = ST_STATUS;
				end else if (out_free) begin
					if (unplaced_q == CW'(1) || (!row_fits && !col_fits)) begin
						state_d = ST_STATUS;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state decode
	always_comb begin
		s_tready   = 1'b0;
		issue      = 1'b0;
		emit_place = 1'b0;
		emit_stat  = 1'b0;
		no_reach   = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   issue = 1'b1;
			ST_PLACE: begin
				emit_place = found_q && out_free;
				no_reach   = !found_q;
			end
			ST_STATUS: emit_stat = out_free;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			min_x_q    <= '0;
			min_z_q    <= '0;
			max_x_q    <= '0;
			max_z_q    <= '0;
			base_y_q   <= '0;
			loaded_q   <= '0;
			unplaced_q <= '0;
			placed_q   <= '0;
			sz_cnt_q   <= '0;
			xb_q       <= '0;
			zb_q       <= '0;
			g_q        <= '0;
			found_q    <= 1'b0;
			outcome_q  <= OUTCOME_OK;
			tag_s1     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s1  <= tag_issue;

			if (cfg_accept) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BOX_MIN_X: min_x_q  <= cfg_data;
					REG_BOX_MIN_Z: min_z_q  <= cfg_data;
					REG_BOX_MAX_X: max_x_q  <= cfg_data;
					REG_BOX_MAX_Z: max_z_q  <= cfg_data;
					REG_BASE_Y:    base_y_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// loading: beats past a full store are dropped
			if (store_we) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (s_accept && s_tlast) begin
				sz_cnt_q <= '0;
				xb_q     <= '0;
				zb_q     <= '0;
			end

			// slot count per axis, capped at MAX_GATES
			if (state_q == ST_SIZE) begin
				sz_cnt_q <= sz_cnt_q + CW'(1);
				if (acc_next <= xsize_q) begin
					xb_q <= xb_q + CW'(1);
				end
				if (acc_next <= zsize_q) begin
					zb_q <= zb_q + CW'(1);
				end
			end

			if (state_q == ST_CHECK) begin
				unplaced_q <= loaded_q;
				placed_q   <= '0;
				g_q        <= '0;
				found_q    <= 1'b0;
				outcome_q  <= few_slots ? OUTCOME_FEW_SLOTS : OUTCOME_OK;
			end

			if (issue) begin
				g_q <= g_q + AW'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end

			if (no_reach) begin
				outcome_q <= OUTCOME_UNREACHED;
			end
			if (emit_place) begin
				placed_q[pick_q] <= 1'b1;
				unplaced_q       <= unplaced_q - CW'(1);
				g_q              <= '0;
				found_q          <= 1'b0;
				// slots exhausted with gates left over
				if (unplaced_q != CW'(1) && !row_fits && !col_fits) begin
					outcome_q <= OUTCOME_FEW_SLOTS;
				end
			end

			if (emit_stat) begin
				loaded_q <= '0;
				placed_q <= '0;
			end

			if (emit_place || emit_stat) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept && s_tlast) begin
			xsize_q  <= SPAN_W'(max_x_q) - SPAN_W'(min_x_q) + ONE_S;
			zsize_q  <= SPAN_W'(max_z_q) - SPAN_W'(min_z_q) + ONE_S;
			sz_acc_q <= '0;
		end
		if (state_q == ST_SIZE) begin
			sz_acc_q <= acc_next;
			reach2_q <= reach_sq;
		end
		if (state_q == ST_CHECK) begin
			col_off_q <= '0;
			row_off_q <= '0;
			best_q    <= reach2_q;
		end

		// strict less-than keeps the lowest index on ties
		if (better) begin
			best_q <= dist2;
			pick_q <= dist_tag.gate[AW-1:0];
		end

		if (emit_place) begin
			m_kind_q    <= KIND_PLACE;
			m_last_q    <= 1'b0;
			m_gnum_q    <= GNUM_W'(pick_q);
			m_x_q       <= COORD_W'(center_x - ONE_S);
			m_y_q       <= base_y_q;
			m_z_q       <= COORD_W'(center_z - ONE_S);
			m_outcome_q <= OUTCOME_OK;
			best_q      <= reach2_q;
			// raster: z within a column, then next column
			if (row_fits) begin
				row_off_q <= row_next;
			end else begin
				row_off_q <= '0;
				col_off_q <= col_next;
			end
		end
		if (emit_stat) begin
			m_kind_q    <= KIND_STATUS;
			m_last_q    <= 1'b1;
			m_gnum_q    <= '0;
			m_x_q       <= '0;
			m_y_q       <= '0;
			m_z_q       <= '0;
			m_outcome_q <= outcome_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {1'b0, m_outcome_q, m_z_q, m_y_q, m_x_q, m_gnum_q};
	assign m_tuser[0] = m_kind_q;
	assign m_tlast    = m_last_q;

	// a gate is never placed twice in one run
	a_pick_unplaced: assert property (@(posedge clk) disable iff (!arst_n)
		emit_place |-> !placed_q[pick_q])
		else $error("picked gate already placed");

	// a placement always has a gate left to place
	a_place_has_gate: assert property (@(posedge clk) disable iff (!arst_n)
		emit_place |-> unplaced_q != '0)
		else $error("placement with no unplaced gate");

	// the load counter never passes the store depth
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= FULL)
		else $error("load count beyond store depth");

	// a status record closes the run and clears its bookkeeping
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_stat |=> (loaded_q == '0) && (placed_q == '0))
		else $error("run state not cleared after status");

	// scanning only happens with gates stored
	a_scan_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (loaded_q != '0))
		else $error("scan with empty store");

endmodule

`default_nettype wire
